/* hw/rtl/alu_bsf_pkg.sv */
// shared types and codes for the data-processing alu with barrel shifter
`timescale 1ns / 1ps
`default_nettype none

package alu_bsf_pkg;

  // alu operation codes
  localparam logic [3:0] OP_AND = 4'd0;
  localparam logic [3:0] OP_EOR = 4'd1;
  localparam logic [3:0] OP_SUB = 4'd2;
  localparam logic [3:0] OP_RSB = 4'd3;
  localparam logic [3:0] OP_ADD = 4'd4;
  localparam logic [3:0] OP_ADC = 4'd5;
  localparam logic [3:0] OP_SBC = 4'd6;
  localparam logic [3:0] OP_RSC = 4'd7;
  localparam logic [3:0] OP_TST = 4'd8;
  localparam logic [3:0] OP_TEQ = 4'd9;
  localparam logic [3:0] OP_CMP = 4'd10;
  localparam logic [3:0] OP_CMN = 4'd11;
  localparam logic [3:0] OP_ORR = 4'd12;
  localparam logic [3:0] OP_MOV = 4'd13;
  localparam logic [3:0] OP_BIC = 4'd14;
  localparam logic [3:0] OP_MVN = 4'd15;

  // shift type codes
  localparam logic [1:0] SH_LSL = 2'd0;
  localparam logic [1:0] SH_LSR = 2'd1;
  localparam logic [1:0] SH_ASR = 2'd2;
  localparam logic [1:0] SH_ROR = 2'd3;

  // flag bit positions
  localparam int FLAG_N = 3;
  localparam int FLAG_Z = 2;
  localparam int FLAG_C = 1;
  localparam int FLAG_V = 0;

  typedef struct packed {
    logic [3:0]  opcode;
    logic        set_flags;
    logic        immediate_form;
    logic        thumb_state;
    logic [11:0] operand_field;
    logic [31:0] first_value;
    logic [31:0] shifted_value;
    logic [7:0]  shift_amount_reg;
  } cmd_item_t;

  typedef struct packed {
    logic [31:0] value;
    logic        carry;
  } shift_res_t;

  typedef struct packed {
    logic [31:0] result_value;
    logic        write_dest;
    logic [3:0]  flags;
  } alu_res_t;

endpackage

`default_nettype wire

/* hw/rtl/alu_bsf_if.sv */
// valid/ready channel interfaces for instructions in and results out
`timescale 1ns / 1ps
`default_nettype none

interface alu_bsf_cmd_if;
  logic        valid;
  logic        ready;
  logic [3:0]  opcode;
  logic        set_flags;
  logic        immediate_form;
  logic        thumb_state;
  logic [11:0] operand_field;
  logic [31:0] first_value;
  logic [31:0] shifted_value;
  logic [7:0]  shift_amount_reg;

  modport source (
    output valid, opcode, set_flags, immediate_form, thumb_state, operand_field,
    output first_value, shifted_value, shift_amount_reg,
    input  ready
  );
  modport sink (
    input  valid, opcode, set_flags, immediate_form, thumb_state, operand_field,
    input  first_value, shifted_value, shift_amount_reg,
    output ready
  );
endinterface

interface alu_bsf_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_value;
  logic        write_dest;
  logic [3:0]  flags_out;

  modport source (
    output valid, result_value, write_dest, flags_out,
    input  ready
  );
  modport sink (
    input  valid, result_value, write_dest, flags_out,
    output ready
  );
endinterface

`default_nettype wire

/* hw/rtl/alu_bsf_shifter.sv */
// operand-two former: rotated immediate, thumb immediate or barrel shift
`timescale 1ns / 1ps
`default_nettype none

module alu_bsf_shifter
  import alu_bsf_pkg::*;
(
  input  wire logic        immediate_form,
  input  wire logic        thumb_state,
  input  wire logic [11:0] operand_field,
  input  wire logic [31:0] shifted_value,
  input  wire logic [7:0]  shift_amount_reg,
  input  wire logic        carry_in,
  output shift_res_t       shift_res
);

  // shift by 1..31, carry in the top bit of the result
  function automatic logic [32:0] shift_small(logic [1:0] sh_kind, logic [31:0] v,
                                              logic [4:0] n);
    logic [32:0] wide;
    logic [63:0] rot;
    logic [32:0] res;
    wide = '0;
    rot  = '0;
    case (sh_kind)
      SH_LSL: begin
        wide = {1'b0, v} << n;
        res  = {wide[32], wide[31:0]};
      end
      SH_LSR: begin
        wide = {v, 1'b0} >> n;
        res  = {wide[0], wide[32:1]};
      end
      SH_ASR: begin
        wide = 33'($signed({v, 1'b0}) >>> n);
        res  = {wide[0], wide[32:1]};
      end
      default: begin
        rot = {v, v} >> n;
        res = {rot[31], rot[31:0]};
      end
    endcase
    return res;
  endfunction

  logic [1:0]  kind;
  logic [4:0]  imm_rot;
  logic [63:0] imm_wide;
  logic [32:0] small_res;
  logic [4:0]  small_n;
  logic [4:0]  imm_amt;

  assign kind     = operand_field[6:5];
  assign imm_rot  = {operand_field[11:8], 1'b0};
  assign imm_wide = {24'd0, operand_field[7:0], 24'd0, operand_field[7:0]} >> imm_rot;
  assign imm_amt  = operand_field[11:7];
  assign small_n  = operand_field[4] ? shift_amount_reg[4:0] : imm_amt;
  assign small_res = shift_small(kind, shifted_value, small_n);

  always_comb begin
    shift_res.value = shifted_value;
    shift_res.carry = carry_in;
    if (immediate_form) begin
      if (thumb_state) begin
        shift_res.value = {20'd0, operand_field};
      end else begin
        shift_res.value = imm_wide[31:0];
        if (imm_rot != 5'd0) begin
          shift_res.carry = imm_wide[31];
        end
      end
    end else if (operand_field[4]) begin
      // amount from register, low byte
      if (shift_amount_reg == 8'd0) begin
        shift_res.value = shifted_value;
      end else if (shift_amount_reg[7:5] == 3'd0) begin
        shift_res.value = small_res[31:0];
        shift_res.carry = small_res[32];
      end else begin
        case (kind)
          SH_LSL: begin
            shift_res.value = '0;
            shift_res.carry = (shift_amount_reg == 8'd32) ? shifted_value[0] : 1'b0;
          end
          SH_LSR: begin
            shift_res.value = '0;
            shift_res.carry = (shift_amount_reg == 8'd32) ? shifted_value[31] : 1'b0;
          end
          SH_ASR: begin
            shift_res.value = {32{shifted_value[31]}};
            shift_res.carry = shifted_value[31];
          end
          default: begin
            // multiple of 32 leaves the value, carry from bit 31
            if (shift_amount_reg[4:0] == 5'd0) begin
              shift_res.value = shifted_value;
              shift_res.carry = shifted_value[31];
            end else begin
              shift_res.value = small_res[31:0];
              shift_res.carry = small_res[32];
            end
          end
        endcase
      end
    end else begin
      if (imm_amt != 5'd0) begin
        shift_res.value = small_res[31:0];
        shift_res.carry = small_res[32];
      end else begin
        // zero amount encodes lsr/asr by 32 and rrx
        case (kind)
          SH_LSL: begin
            shift_res.value = shifted_value;
          end
          SH_LSR: begin
            shift_res.value = '0;
            shift_res.carry = shifted_value[31];
          end
          SH_ASR: begin
            shift_res.value = {32{shifted_value[31]}};
            shift_res.carry = shifted_value[31];
          end
          default: begin
            shift_res.value = {carry_in, shifted_value[31:1]};
            shift_res.carry = shifted_value[0];
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/alu_bsf_alu.sv */
// sixteen-operation alu with nzcv flag update
`timescale 1ns / 1ps
`default_nettype none

module alu_bsf_alu
  import alu_bsf_pkg::*;
(
  input  wire logic [3:0]  opcode,
  input  wire logic        set_flags,
  input  wire logic [31:0] first_value,
  input  wire shift_res_t  shift_res,
  input  wire logic [3:0]  flags,
  output alu_res_t         alu_res
);

  logic [31:0] a;
  logic [31:0] b;
  logic [31:0] x;
  logic [31:0] y;
  logic        k;
  logic        arith;
  logic [31:0] logic_res;
  logic [32:0] sum;
  logic [31:0] res;
  logic        carry;
  logic        ovf;
  logic        wr;

  assign a = first_value;
  assign b = shift_res.value;

  always_comb begin
    x         = a;
    y         = b;
    k         = 1'b0;
    arith     = 1'b0;
    logic_res = '0;
    case (opcode)
      OP_AND, OP_TST: logic_res = a & b;
      OP_EOR, OP_TEQ: logic_res = a ^ b;
      OP_SUB, OP_CMP: begin
        arith = 1'b1;
        y     = ~b;
        k     = 1'b1;
      end
      OP_RSB: begin
        arith = 1'b1;
        x     = b;
        y     = ~a;
        k     = 1'b1;
      end
      OP_ADD, OP_CMN: arith = 1'b1;
      OP_ADC: begin
        arith = 1'b1;
        k     = flags[FLAG_C];
      end
      OP_SBC: begin
        arith = 1'b1;
        y     = ~b;
        k     = flags[FLAG_C];
      end
      OP_RSC: begin
        arith = 1'b1;
        x     = b;
        y     = ~a;
        k     = flags[FLAG_C];
      end
      OP_ORR: logic_res = a | b;
      OP_MOV: logic_res = b;
      OP_BIC: logic_res = a & ~b;
      default: logic_res = ~b;
    endcase
  end

  assign sum = {1'b0, x} + {1'b0, y} + {32'd0, k};

  always_comb begin
    if (arith) begin
      res   = sum[31:0];
      carry = sum[32];
      ovf   = (x[31] ^ sum[31]) & (y[31] ^ sum[31]);
    end else begin
      res   = logic_res;
      carry = shift_res.carry;
      ovf   = flags[FLAG_V];
    end
  end

  assign wr = !(opcode == OP_TST || opcode == OP_TEQ || opcode == OP_CMP ||
                opcode == OP_CMN);

  assign alu_res.result_value = wr ? res : 32'd0;
  assign alu_res.write_dest   = wr;
  assign alu_res.flags        = set_flags ? {res[31], res == 32'd0, carry, ovf} : flags;

endmodule

`default_nettype wire

/* hw/rtl/alu_barrel_shift_flags_top.sv */
// channel   | direction | payload
// cmd       | in        | opcode, set_flags, immediate_form, thumb_state, operand_field,
//           |           | first_value, shifted_value, shift_amount_reg
// res       | out       | result_value, write_dest, flags_out
//
// one item per cycle when res is ready, through the input and then the output register
// the rate is set by the flags loop: shifter, adder and flag update are combinational
// reset clears both valid bits and the nzcv flags to zero
// a stalled result holds in the output register; the input register keeps taking
// an item whenever it is empty or its item moves on in the same cycle
`timescale 1ns / 1ps
`default_nettype none

module alu_barrel_shift_flags_top
  import alu_bsf_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  alu_bsf_cmd_if.sink   cmd,
  alu_bsf_res_if.source res
);

  logic       in_valid;
  cmd_item_t  in_item;
  logic       out_valid;
  alu_res_t   out_item;
  logic [3:0] nzcv_flags;

  shift_res_t shift_res;
  alu_res_t   alu_res;
  logic       advance;
  logic       take;

  assign advance   = in_valid && (!out_valid || res.ready);
  assign cmd.ready = !in_valid || advance;
  assign take      = cmd.valid && cmd.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (cmd.ready) begin
      in_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_item.opcode           <= cmd.opcode;
      in_item.set_flags        <= cmd.set_flags;
      in_item.immediate_form   <= cmd.immediate_form;
      in_item.thumb_state      <= cmd.thumb_state;
      in_item.operand_field    <= cmd.operand_field;
      in_item.first_value      <= cmd.first_value;
      in_item.shifted_value    <= cmd.shifted_value;
      in_item.shift_amount_reg <= cmd.shift_amount_reg;
    end
  end

  alu_bsf_shifter u_shifter (
    .immediate_form   (in_item.immediate_form),
    .thumb_state      (in_item.thumb_state),
    .operand_field    (in_item.operand_field),
    .shifted_value    (in_item.shifted_value),
    .shift_amount_reg (in_item.shift_amount_reg),
    .carry_in         (nzcv_flags[FLAG_C]),
    .shift_res        (shift_res)
  );

  alu_bsf_alu u_alu (
    .opcode      (in_item.opcode),
    .set_flags   (in_item.set_flags),
    .first_value (in_item.first_value),
    .shift_res   (shift_res),
    .flags       (nzcv_flags),
    .alu_res     (alu_res)
  );

  // flags move with the item into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      nzcv_flags <= 4'd0;
    end else if (advance) begin
      out_valid  <= 1'b1;
      nzcv_flags <= alu_res.flags;
    end else if (res.ready) begin
      out_valid  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= alu_res;
    end
  end

  assign res.valid        = out_valid;
  assign res.result_value = out_item.result_value;
  assign res.write_dest   = out_item.write_dest;
  assign res.flags_out    = out_item.flags;

endmodule

`default_nettype wire

/* hw/rtl/alu_bsf_checker.sv */
// port-level checks for the alu top level, bound to it
`timescale 1ns / 1ps
`default_nettype none

module alu_bsf_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        cmd_valid,
  input wire logic        cmd_ready,
  input wire logic        res_valid,
  input wire logic        res_ready,
  input wire logic [31:0] result_value,
  input wire logic        write_dest,
  input wire logic [3:0]  flags_out
);

  // no result straight after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // test and compare items carry a zero value
  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !write_dest) |-> (result_value == 32'd0))
    else $error("nonzero value without write");

  // an accepted item passes the input register and, with the far side ready, reaches the output register
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready) ##1 res_ready |=> res_valid)
    else $error("item did not reach the output");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=>
      (res_valid && $stable(result_value) && $stable(write_dest) && $stable(flags_out)))
    else $error("stalled result changed");

endmodule

bind alu_barrel_shift_flags_top alu_bsf_checker u_alu_bsf_checker (
  .clk          (clk),
  .rst          (rst),
  .cmd_valid    (cmd.valid),
  .cmd_ready    (cmd.ready),
  .res_valid    (res.valid),
  .res_ready    (res.ready),
  .result_value (res.result_value),
  .write_dest   (res.write_dest),
  .flags_out    (res.flags_out)
);

`default_nettype wire
